>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check an implication (or plain property) on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> src/crlp_pkg.sv
// ----------------------------------------------------------------------------
// crlp_pkg
// Shared constants, word table and result type of the call-range list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package crlp_pkg;

    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int OUT_W            = 32;
    localparam int WORD_COUNT       = 5;
    localparam int WORD_MAX         = 12;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_LOWZ  = 8'h7A;

    // Range kinds
    localparam logic [1:0] KIND_ALL    = 2'd0;
    localparam logic [1:0] KIND_FRAME  = 2'd1;
    localparam logic [1:0] KIND_TARGET = 2'd2;
    localparam logic [1:0] KIND_RENDER = 2'd3;

    // Error kinds
    localparam logic [1:0] ERR_EXPECT_DIGIT = 2'd0;
    localparam logic [1:0] ERR_EXPECT_WORD  = 2'd1;
    localparam logic [1:0] ERR_UNKNOWN_WORD = 2'd2;

    // Words, left-justified and space padded to WORD_MAX characters
    localparam logic [WORD_MAX*8-1:0] WORD_TEXT [WORD_COUNT] = '{
        "frame       ",
        "rendertarget",
        "fbo         ",
        "render      ",
        "draw        "
    };
    localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{4'd5, 4'd12, 4'd3, 4'd6, 4'd4};
    localparam logic [1:0] WORD_KIND [WORD_COUNT] = '{
        KIND_FRAME, KIND_TARGET, KIND_TARGET, KIND_RENDER, KIND_RENDER
    };

    typedef struct packed {
        logic             range_valid;
        logic [OUT_W-1:0] range_start;
        logic [OUT_W-1:0] range_stop;
        logic [OUT_W-1:0] range_step;
        logic [1:0]       range_kind;
        logic             syntax_error;
        logic [1:0]       error_kind;
        logic             text_done;
    } t_result;

    // Character of word idx at position pos; valid for pos below WORD_MAX
    function automatic logic [7:0] word_char(input int idx, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        if (pos < 4'(WORD_MAX)) begin
            c = WORD_TEXT[idx][(WORD_MAX - 1 - int'(pos)) * 8 +: 8];
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/crlp_if.sv
// ----------------------------------------------------------------------------
// crlp_if
// Valid/ready channels of the call-range list parser: text bytes in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface crlp_in_if import crlp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface crlp_out_if import crlp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             range_valid;
    logic [OUT_W-1:0] range_start;
    logic [OUT_W-1:0] range_stop;
    logic [OUT_W-1:0] range_step;
    logic [1:0]       range_kind;
    logic             syntax_error;
    logic [1:0]       error_kind;
    logic             text_done;

    modport source (
        output valid, output range_valid, output range_start, output range_stop,
        output range_step, output range_kind, output syntax_error,
        output error_kind, output text_done, input ready
    );
    modport sink (
        input valid, input range_valid, input range_start, input range_stop,
        input range_step, input range_kind, input syntax_error,
        input error_kind, input text_done, output ready
    );
endinterface

`default_nettype wire

>>> src/crlp_core.sv
// ----------------------------------------------------------------------------
// crlp_core
// Parser state and per-byte next-state logic; advances on each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module crlp_core import crlp_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [7:0] i_ch,
    output t_result         o_res
);

    localparam int NW = NUMBER_WIDTH;

    localparam logic [3:0] PH_START       = 4'd0;
    localparam logic [3:0] PH_START_NUM   = 4'd1;
    localparam logic [3:0] PH_AFTER_START = 4'd2;
    localparam logic [3:0] PH_AFTER_DASH  = 4'd3;
    localparam logic [3:0] PH_STOP_NUM    = 4'd4;
    localparam logic [3:0] PH_AFTER_BODY  = 4'd5;
    localparam logic [3:0] PH_AFTER_SLASH = 4'd6;
    localparam logic [3:0] PH_STEP_NUM    = 4'd7;
    localparam logic [3:0] PH_WORD        = 4'd8;
    localparam logic [3:0] PH_AFTER_RANGE = 4'd9;

    localparam logic [NW-1:0] NUM_ONES = {NW{1'b1}};
    localparam logic [NW-1:0] NUM_ONE  = {{(NW-1){1'b0}}, 1'b1};
    localparam logic [4:0]    CAND_ALL = {WORD_COUNT{1'b1}};

    logic [3:0]    r_phase, n_phase;
    logic [NW-1:0] r_start, n_start;
    logic [NW-1:0] r_stop,  n_stop;
    logic [NW-1:0] r_step,  n_step;
    logic [NW-1:0] r_acc,   n_acc;
    logic [3:0]    r_wpos,  n_wpos;
    logic [4:0]    r_cand,  n_cand;
    logic [1:0]    r_kind,  n_kind;
    logic          r_hold,  n_hold;

    logic          is_dig, is_alp, is_spc, is_nul, is_comma;
    logic [NW-1:0] digit, acc_next;
    logic [4:0]    cand_first, cand_cont;
    logic [3:0]    wpos_inc;
    logic          word_hit;
    logic [1:0]    hit_kind;

    logic          do_end, do_start, do_err, do_resolve;
    logic [1:0]    err_code;
    logic [NW+OUT_W-1:0] ext_start, ext_stop, ext_step;

    // Drop every candidate whose next letter does not match
    function automatic logic [4:0] feed(input logic [4:0] cand, input logic [3:0] pos,
                                        input logic [7:0] c);
        logic [4:0] res;
        res = cand;
        for (int i = 0; i < WORD_COUNT; i++) begin
            if (cand[i] && (pos >= WORD_LEN[i] || word_char(i, pos) != c)) begin
                res[i] = 1'b0;
            end
        end
        return res;
    endfunction

    assign is_dig   = (i_ch >= CH_DIG0) && (i_ch <= CH_DIG9);
    assign is_alp   = (i_ch >= CH_LOWA) && (i_ch <= CH_LOWZ);
    assign is_spc   = (i_ch == CH_SPACE) || (i_ch == CH_TAB) ||
                      (i_ch == CH_CR) || (i_ch == CH_LF);
    assign is_nul   = (i_ch == CH_NUL);
    assign is_comma = (i_ch == CH_COMMA);

    assign digit    = {{(NW-4){1'b0}}, i_ch[3:0]};
    assign acc_next = (r_acc << 3) + (r_acc << 1) + digit;

    assign cand_first = feed(CAND_ALL, 4'd0, i_ch);
    assign cand_cont  = feed(r_cand, r_wpos, i_ch);
    assign wpos_inc   = (r_wpos == 4'hF) ? r_wpos : r_wpos + 4'd1;

    always_comb begin
        word_hit = 1'b0;
        hit_kind = KIND_ALL;
        for (int i = 0; i < WORD_COUNT; i++) begin
            if (!word_hit && r_cand[i] && (r_wpos == WORD_LEN[i])) begin
                word_hit = 1'b1;
                hit_kind = WORD_KIND[i];
            end
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_start    = r_start;
        n_stop     = r_stop;
        n_step     = r_step;
        n_acc      = r_acc;
        n_wpos     = r_wpos;
        n_cand     = r_cand;
        n_kind     = r_kind;
        n_hold     = r_hold;
        o_res      = '0;
        do_end     = 1'b0;
        do_start   = 1'b0;
        do_err     = 1'b0;
        do_resolve = 1'b0;
        err_code   = ERR_EXPECT_DIGIT;
        ext_start  = '0;
        ext_stop   = '0;
        ext_step   = '0;

        if (r_hold) begin
            if (is_nul) begin
                n_hold          = 1'b0;
                n_phase         = PH_START;
                o_res.text_done = 1'b1;
            end
        end else begin
            unique case (r_phase)
                PH_START_NUM: begin
                    if (is_dig) begin
                        n_acc = acc_next;
                    end else begin
                        n_start = r_acc;
                        if (is_spc) begin
                            n_phase = PH_AFTER_START;
                        end else if (i_ch == CH_DASH) begin
                            n_stop  = NUM_ONES;
                            n_phase = PH_AFTER_DASH;
                        end else if (i_ch == CH_SLASH) begin
                            n_stop  = r_acc;
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            n_stop = r_acc;
                            do_end = 1'b1;
                        end
                    end
                end
                PH_AFTER_START: begin
                    if (!is_spc) begin
                        if (i_ch == CH_DASH) begin
                            n_stop  = NUM_ONES;
                            n_phase = PH_AFTER_DASH;
                        end else if (i_ch == CH_SLASH) begin
                            n_stop  = r_start;
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            n_stop = r_start;
                            do_end = 1'b1;
                        end
                    end
                end
                PH_AFTER_DASH: begin
                    if (!is_spc) begin
                        if (is_dig) begin
                            n_acc   = digit;
                            n_phase = PH_STOP_NUM;
                        end else if (i_ch == CH_SLASH) begin
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
                PH_STOP_NUM: begin
                    if (is_dig) begin
                        n_acc = acc_next;
                    end else begin
                        n_stop = r_acc;
                        if (is_spc) begin
                            n_phase = PH_AFTER_BODY;
                        end else if (i_ch == CH_SLASH) begin
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
                PH_AFTER_BODY: begin
                    if (!is_spc) begin
                        if (i_ch == CH_SLASH) begin
                            n_phase = PH_AFTER_SLASH;
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
                PH_AFTER_SLASH: begin
                    if (!is_spc) begin
                        if (is_dig) begin
                            n_acc   = digit;
                            n_phase = PH_STEP_NUM;
                        end else if (is_alp) begin
                            n_wpos  = 4'd1;
                            n_cand  = cand_first;
                            n_phase = PH_WORD;
                        end else begin
                            do_err   = 1'b1;
                            err_code = ERR_EXPECT_WORD;
                        end
                    end
                end
                PH_STEP_NUM: begin
                    if (is_dig) begin
                        n_acc = acc_next;
                    end else begin
                        n_step = r_acc;
                        do_end = 1'b1;
                    end
                end
                PH_WORD: begin
                    if (is_alp) begin
                        n_cand = cand_cont;
                        n_wpos = wpos_inc;
                    end else begin
                        do_resolve = 1'b1;
                    end
                end
                PH_AFTER_RANGE: begin
                    if (!is_spc) begin
                        if (is_comma) begin
                            n_phase = PH_START;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            // Close a word: known word ends the range, anything else is an error
            if (do_resolve) begin
                if (word_hit) begin
                    n_kind = hit_kind;
                    do_end = 1'b1;
                end else begin
                    do_err   = 1'b1;
                    err_code = ERR_UNKNOWN_WORD;
                end
            end

            // Emit the finished range, then treat the byte as a separator or a new start
            if (do_end) begin
                ext_start         = {{OUT_W{1'b0}}, n_start};
                ext_stop          = {{OUT_W{1'b0}}, n_stop};
                ext_step          = {{OUT_W{1'b0}}, n_step};
                o_res.range_valid = 1'b1;
                o_res.range_start = ext_start[OUT_W-1:0];
                o_res.range_stop  = ext_stop[OUT_W-1:0];
                o_res.range_step  = ext_step[OUT_W-1:0];
                o_res.range_kind  = n_kind;
                if (is_comma) begin
                    n_phase = PH_START;
                end else if (is_spc) begin
                    n_phase = PH_AFTER_RANGE;
                end else begin
                    do_start = 1'b1;
                end
            end

            if (do_start) begin
                if (is_nul) begin
                    o_res.text_done = 1'b1;
                    n_phase         = PH_START;
                end else if (is_spc) begin
                    n_phase = PH_START;
                end else if (is_alp) begin
                    n_start = '0;
                    n_stop  = NUM_ONES;
                    n_step  = NUM_ONE;
                    n_kind  = KIND_ALL;
                    n_wpos  = 4'd1;
                    n_cand  = cand_first;
                    n_phase = PH_WORD;
                end else if (i_ch == CH_STAR) begin
                    n_start = '0;
                    n_stop  = NUM_ONES;
                    n_step  = NUM_ONE;
                    n_kind  = KIND_ALL;
                    n_phase = PH_AFTER_BODY;
                end else if (is_dig) begin
                    n_step  = NUM_ONE;
                    n_kind  = KIND_ALL;
                    n_acc   = digit;
                    n_phase = PH_START_NUM;
                end else begin
                    do_err   = 1'b1;
                    err_code = ERR_EXPECT_DIGIT;
                end
            end

            // An error on the end-of-text byte leaves no hold
            if (do_err) begin
                o_res.syntax_error = 1'b1;
                o_res.error_kind   = err_code;
                n_phase            = PH_START;
                if (is_nul) begin
                    o_res.text_done = 1'b1;
                    n_hold          = 1'b0;
                end else begin
                    n_hold = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_start <= '0;
            r_stop  <= NUM_ONES;
            r_step  <= NUM_ONE;
            r_acc   <= '0;
            r_wpos  <= 4'd0;
            r_cand  <= CAND_ALL;
            r_kind  <= KIND_ALL;
            r_hold  <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_stop  <= n_stop;
            r_step  <= n_step;
            r_acc   <= n_acc;
            r_wpos  <= n_wpos;
            r_cand  <= n_cand;
            r_kind  <= n_kind;
            r_hold  <= n_hold;
        end
    end

endmodule

`default_nettype wire

>>> src/call_range_list_parser.sv
// ----------------------------------------------------------------------------
// call_range_list_parser
// Streams text bytes and reports call ranges (start, stop, step, kind) and
// syntax errors, one result per byte.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                                   | one request is
//   ---------+-----+-------------------------------------------+------------------
//   i_in     | in  | ch[7:0]                                   | one text byte
//   o_out    | out | range_*, syntax_error, error_kind, done   | one byte's result
//
// Each byte is handled at its accepting edge: the parser state advances there
// and the result lands in the output register on that same edge.
// A new byte is taken every cycle while the output register is empty or being
// drained; only a stalled, full output register holds off the input.
// Reset is synchronous, active low: the parser waits for a range start, no
// error hold, and the output register is empty.
//
`default_nettype none

`include "assert_macros.svh"

module call_range_list_parser import crlp_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    crlp_in_if.sink    i_in,
    crlp_out_if.source o_out
);

    logic    accept;
    t_result core_res;
    t_result r_out;
    logic    r_out_valid;

    // Take a request whenever the output register is free or is being emptied
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    crlp_core #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_ch    (i_in.ch),
        .o_res   (core_res)
    );

    // Output register: load on accept, drop once taken, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.range_valid  = r_out.range_valid;
    assign o_out.range_start  = r_out.range_start;
    assign o_out.range_stop   = r_out.range_stop;
    assign o_out.range_step   = r_out.range_step;
    assign o_out.range_kind   = r_out.range_kind;
    assign o_out.syntax_error = r_out.syntax_error;
    assign o_out.error_kind   = r_out.error_kind;
    assign o_out.text_done    = r_out.text_done;

    `ASSERT_ALWAYS(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !o_out.ready |-> !i_in.ready, "input taken while result stalled")
    `ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, accept, o_out.valid, "accepted byte left no result")
    `ASSERT_ALWAYS(a_error_kind_clear, i_clk, i_rst_n, o_out.valid && !o_out.syntax_error |-> o_out.error_kind == ERR_EXPECT_DIGIT, "error kind without error")
    `ASSERT_ALWAYS(a_range_fields_clear, i_clk, i_rst_n, o_out.valid && !o_out.range_valid |-> o_out.range_start == '0 && o_out.range_step == '0 && o_out.range_kind == KIND_ALL, "range fields set without range")

endmodule

`default_nettype wire
